// File: src/sli_pkg.sv
// Shared types and constants for the sorted list insert/delete unit.
// Used by sli_cell, sorted_list_insert_delete_unit and tb; no dependencies.
package sli_pkg;

    localparam int DefaultCapacity = 16;
    localparam int DataWidth       = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STAT_INSERTED = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_DELETED  = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_LISTED   = 3'd4,
        STAT_EMPTY    = 3'd5
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        op_t                          opcode;
        logic signed [DataWidth-1:0]  value;
    } in_item_t;

    typedef struct packed {
        status_t                      status;
        logic signed [DataWidth-1:0]  entry;
        logic                         last;
    } out_item_t;

    typedef struct packed {
        cell_cmd_t                    cmd;
        logic signed [DataWidth-1:0]  value;
        logic                         found;
    } cell_ctrl_t;

endpackage

// File: src/sli_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast value and shifts with its neighbors. Depends on sli_pkg.
module sli_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                                   clk,
    input  sli_pkg::cell_ctrl_t                    ctrl,
    input  logic [CNT_W-1:0]                       count,
    input  logic signed [sli_pkg::DataWidth-1:0]   left_entry,
    input  logic                                   left_less,
    input  logic signed [sli_pkg::DataWidth-1:0]   right_entry,
    input  logic signed [sli_pkg::DataWidth-1:0]   head_entry,
    output logic signed [sli_pkg::DataWidth-1:0]   entry,
    output logic                                   less,
    output logic                                   match
);

    localparam logic [CNT_W-1:0] MyIdx  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MyNext = CNT_W'(IDX + 1);

    logic signed [sli_pkg::DataWidth-1:0] entry_reg;
    logic signed [sli_pkg::DataWidth-1:0] entry_next;
    logic                                 in_range;
    logic                                 at_pos;

    assign in_range = MyIdx < count;
    assign less     = in_range && (entry_reg < ctrl.value);
    // first slot not smaller than the value
    assign at_pos   = !less && left_less;
    assign match    = at_pos && in_range && (entry_reg == ctrl.value);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.cmd)
            sli_pkg::CMD_INSERT:
            begin
                if (!less)
                begin
                    entry_next = at_pos ? ctrl.value : left_entry;
                end
            end
            sli_pkg::CMD_DELETE:
            begin
                if (ctrl.found && !less)
                begin
                    entry_next = right_entry;
                end
            end
            sli_pkg::CMD_ROTATE:
            begin
                // tail of the occupied run takes the head back
                entry_next = (MyNext == count) ? head_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: src/sorted_list_insert_delete_unit.sv
// Sorted list insert/delete unit: top level with control FSM, occupancy
// count and result register, around a chain of sli_cell. Depends on sli_pkg.
//
// Usage: items enter on in_valid/in_ready (opcode, value) and results
// leave on out_valid/out_ready (status, entry, last); a transfer happens
// when valid and ready are both high. Up to CAPACITY signed values are
// held in ascending order, one per cell of the chain.
// Insert and delete are done by all cells at once in the accept cycle:
// the result is valid the next cycle, and a new item can be taken every
// cycle while the receiver keeps up. Insert on a full list is dropped
// with a full status; delete of an absent value reports not found.
// A list item rotates the chain one cell per cycle while the receiver
// keeps up, sending the head entry each time: n results (one empty result
// if the list holds nothing), with last set on the final one; no item is
// taken while a list is streaming. Opcode 3 is taken and gives nothing.
// When the receiver stalls, the result register holds and the input
// side is held off until it drains; the chain does not advance.
// Reset empties the list (count to zero) and clears the result valid.
module sorted_list_insert_delete_unit #(
    parameter int CAPACITY = sli_pkg::DefaultCapacity
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sli_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sli_pkg::out_item_t  out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] OneCount = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    logic                 out_valid_reg, out_valid_next;
    sli_pkg::out_item_t   out_reg, out_next;

    sli_pkg::cell_ctrl_t  ctrl;
    logic                 out_free;
    logic                 accept;
    logic                 found;

    logic signed [sli_pkg::DataWidth-1:0] entries [CAPACITY];
    logic                                 less_v  [CAPACITY];
    logic [CAPACITY-1:0]                  match_v;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign found     = |match_v;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [sli_pkg::DataWidth-1:0] left_e;
            logic signed [sli_pkg::DataWidth-1:0] right_e;
            logic                                 left_l;

            if (g == 0)
            begin : g_head
                assign left_e = '0;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = entries[g-1];
                assign left_l = less_v[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_body
                assign right_e = entries[g+1];
            end

            sli_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .left_entry  (left_e),
                .left_less   (left_l),
                .right_entry (right_e),
                .head_entry  (entries[0]),
                .entry       (entries[g]),
                .less        (less_v[g]),
                .match       (match_v[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ctrl.cmd       = sli_pkg::CMD_NONE;
        ctrl.value     = in_data.value;
        ctrl.found     = found;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_next.entry = in_data.value;
                    out_next.last  = 1'b1;
                    unique case (in_data.opcode)
                        sli_pkg::OP_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg < CapCount)
                            begin
                                ctrl.cmd       = sli_pkg::CMD_INSERT;
                                count_next     = count_reg + OneCount;
                                out_next.status = sli_pkg::STAT_INSERTED;
                            end
                            else
                            begin
                                out_next.status = sli_pkg::STAT_FULL;
                            end
                        end
                        sli_pkg::OP_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            ctrl.cmd       = sli_pkg::CMD_DELETE;
                            if (found)
                            begin
                                count_next      = count_reg - OneCount;
                                out_next.status = sli_pkg::STAT_DELETED;
                            end
                            else
                            begin
                                out_next.status = sli_pkg::STAT_NOTFOUND;
                            end
                        end
                        sli_pkg::OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = sli_pkg::STAT_EMPTY;
                                out_next.entry  = '0;
                            end
                            else
                            begin
                                remain_next = count_reg;
                                state_next  = ST_LIST;
                            end
                        end
                        default:
                        begin
                            // unused opcode: drop
                            out_next = out_reg;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    ctrl.cmd        = sli_pkg::CMD_ROTATE;
                    out_valid_next  = 1'b1;
                    out_next.status = sli_pkg::STAT_LISTED;
                    out_next.entry  = entries[0];
                    out_next.last   = (remain_reg == OneCount);
                    remain_next     = remain_reg - OneCount;
                    if (remain_reg == OneCount)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: tb/sv/tb.sv
// Testbench for sorted_list_insert_delete_unit: directed and random insert, delete and
// list commands, checked against a tracking copy of the sorted store.
// Depends on sli_pkg and the unit's RTL.
module tb;
    import sli_pkg::*;

    localparam int Capacity    = DefaultCapacity;
    localparam int RandomItems = 300;
    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 20;
    localparam int LongHold    = 90;
    localparam int MaxGap      = 12;
    localparam logic [1:0] OpUnused = 2'd3;
    localparam logic signed [DataWidth-1:0] MinValue = 32'sh8000_0000;
    localparam logic signed [DataWidth-1:0] MaxValue = 32'sh7FFF_FFFF;

    // Tracks the sorted store and queues the results each command should produce
    class list_tracker;
        localparam int Depth = sli_pkg::DefaultCapacity;

        logic signed [sli_pkg::DataWidth-1:0] slots [Depth];
        int fill;
        sli_pkg::out_item_t pending_results [$];
        int errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            if (errors < 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push_result(sli_pkg::status_t st,
                                  logic signed [sli_pkg::DataWidth-1:0] v, logic lst);
            sli_pkg::out_item_t r;
            r.status = st;
            r.entry  = v;
            r.last   = lst;
            pending_results.push_back(r);
        endfunction

        function void take_command(sli_pkg::in_item_t cmd);
            int pos;
            int i;
            case (cmd.opcode)
                sli_pkg::OP_INSERT:
                begin
                    if (fill >= Depth)
                        push_result(sli_pkg::STAT_FULL, cmd.value, 1'b1);
                    else
                    begin
                        // place ahead of the first stored value that is not smaller
                        pos = 0;
                        while (pos < fill && slots[pos] < cmd.value)
                            pos++;
                        for (i = fill; i > pos; i--)
                            slots[i] = slots[i-1];
                        slots[pos] = cmd.value;
                        fill++;
                        push_result(sli_pkg::STAT_INSERTED, cmd.value, 1'b1);
                    end
                end
                sli_pkg::OP_DELETE:
                begin
                    pos = 0;
                    while (pos < fill && slots[pos] !== cmd.value)
                        pos++;
                    if (pos >= fill)
                        push_result(sli_pkg::STAT_NOTFOUND, cmd.value, 1'b1);
                    else
                    begin
                        for (i = pos; i + 1 < fill; i++)
                            slots[i] = slots[i+1];
                        fill--;
                        push_result(sli_pkg::STAT_DELETED, cmd.value, 1'b1);
                    end
                end
                sli_pkg::OP_LIST:
                begin
                    if (fill == 0)
                        push_result(sli_pkg::STAT_EMPTY, '0, 1'b1);
                    else
                        for (i = 0; i < fill; i++)
                            push_result(sli_pkg::STAT_LISTED, slots[i], i == fill - 1);
                end
                default:
                    ;
            endcase
        endfunction

        task match_result(input sli_pkg::out_item_t got);
            sli_pkg::out_item_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result status %0d entry %0d last %0b",
                                 got.status, got.entry, got.last));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.entry !== want.entry)
                report($sformatf("entry %0d, expected %0d", got.entry, want.entry));
            if (got.last !== want.last)
                report($sformatf("last %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    list_tracker tracker;
    bit send_fast;
    bit recv_fast;
    logic signed [DataWidth-1:0] value_pool [8];

    sorted_list_insert_delete_unit #(
        .CAPACITY(Capacity)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one command and hold it until the transfer
    task automatic issue(input logic [1:0] op, input logic signed [DataWidth-1:0] v);
        in_item_t item;
        int gap;
        item.opcode = op_t'(op);
        item.value  = v;
        if ($urandom_range(0, 19) == 0)
            send_fast = !send_fast;
        gap = send_fast ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_command(item);
    endtask

    function automatic void refresh_pool();
        int i;
        for (i = 0; i < 8; i++)
            value_pool[i] = (i < 5) ? $signed($urandom_range(0, 20)) - 10 : $urandom;
    endfunction

    // Mostly pool values so deletes find their target and duplicates occur
    function automatic logic signed [DataWidth-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return value_pool[$urandom_range(0, 7)];
        if (r == 6)
            return $urandom_range(0, 1) ? MinValue : MaxValue;
        return $urandom;
    endfunction

    // Stimulus
    initial
    begin
        int sent;
        int phase_left;
        bit growing;
        int r;
        int i;
        logic [1:0] op;

        tracker = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, absent delete, unused opcode, extremes, duplicates
        issue(OP_LIST, 32'sd0);
        issue(OP_DELETE, 32'sd7);
        issue(OpUnused, 32'shFFFF_FFFF);
        issue(OP_INSERT, MaxValue);
        issue(OP_INSERT, MinValue);
        issue(OP_INSERT, 32'sd0);
        issue(OP_INSERT, 32'sd0);
        issue(OP_INSERT, -32'sd1);
        issue(OP_LIST, 32'sd0);
        issue(OP_DELETE, 32'sd0);
        issue(OP_DELETE, 32'sd5);
        issue(OP_DELETE, MinValue);
        // fill up, overflow once, then stream the full list
        for (i = 0; i < Capacity - 3; i++)
            issue(OP_INSERT, (i % 2) ? $signed($urandom) : i - 6);
        issue(OP_INSERT, 32'sd3);
        issue(OP_LIST, 32'sd0);
        issue(OP_DELETE, MaxValue);

        // Random: alternate growing and shrinking phases
        sent = 0;
        growing = 1'b1;
        phase_left = $urandom_range(25, 50);
        refresh_pool();
        while (sent < RandomItems)
        begin
            if (phase_left == 0)
            begin
                growing = !growing;
                phase_left = $urandom_range(25, 50);
                refresh_pool();
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (growing)
                op = (r < 65) ? OP_INSERT : (r < 82) ? OP_DELETE : (r < 96) ? OP_LIST : OpUnused;
            else
                op = (r < 20) ? OP_INSERT : (r < 75) ? OP_DELETE : (r < 93) ? OP_LIST : OpUnused;
            issue(op, pick_value());
            sent++;
        end
        in_valid <= 1'b0;

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random stalls, two long hold-offs to back up the input
    initial
    begin
        int hold;
        int taken;
        hold = 0;
        taken = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                tracker.match_result(out_data);
                taken++;
                if ($urandom_range(0, 19) == 0)
                    recv_fast = !recv_fast;
                hold = recv_fast ? 0 : $urandom_range(0, MaxGap);
                if (taken == 40 || taken == 260)
                    hold = LongHold;
            end
            else if (hold > 0)
                hold--;
            out_ready <= (hold == 0);
        end
    end

    // Watchdog: count cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < StallLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
